>>> hdl/swld_pkg.sv
// Shared types and constants for the sync word length deframer.
`timescale 1ns / 1ps

package swld_pkg;

  // Parser phase codes.
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } swld_phase_t;

  localparam logic [31:0] SYNC_WORD       = 32'hAABB_CCDD;
  localparam int          LEN_FIRST_BYTE  = 4;   // first header byte of the length
  localparam int          LEN_END_BYTE    = 8;   // one past the last length byte
  localparam int          FRAME_LEN_W     = 24;
  localparam int          BYTE_W          = 8;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_RESET = FRAME_LEN_W'(1024 * 300);

  // One payload result handed from the parser to the output register.
  typedef struct packed {
    logic                   valid;
    logic [BYTE_W-1:0]      data;
    logic                   last;
    logic [FRAME_LEN_W-1:0] length;
  } swld_result_t;

endpackage

>>> hdl/swld_parser.sv
// Byte-at-a-time sync hunt, header collection and payload marking.
`timescale 1ns / 1ps

module swld_parser #(
  parameter int HEADER_BYTES = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_fire,
  input  logic [swld_pkg::BYTE_W-1:0]         in_byte,
  input  logic [swld_pkg::FRAME_LEN_W-1:0]    max_frame_len,
  output swld_pkg::swld_result_t              result
);
  import swld_pkg::*;

  localparam int HCW = $clog2(HEADER_BYTES + 1);

  swld_phase_t            phase, phase_next;
  logic [23:0]            sync_window, sync_window_next;
  logic [HCW-1:0]         header_count, header_count_next;
  logic [31:0]            length_value, length_value_next;
  logic [FRAME_LEN_W-1:0] payload_count, payload_count_next;

  logic [31:0]            window;
  logic                   sync_hit;
  logic [HCW-1:0]         header_inc;
  logic                   header_done;
  logic [31:0]            length_new;
  logic                   length_bad;
  logic [FRAME_LEN_W-1:0] payload_inc;
  logic                   payload_last;

  assign window      = {sync_window, in_byte};
  assign sync_hit    = (window == SYNC_WORD);
  assign header_inc  = header_count + HCW'(1);
  assign header_done = (header_inc >= HCW'(HEADER_BYTES));

  // Little-endian length assembly over header bytes four to seven.
  always_comb begin
    length_new = length_value;
    if (header_count >= HCW'(LEN_FIRST_BYTE) && header_count < HCW'(LEN_END_BYTE)) begin
      case (header_count[1:0])
        2'd0:    length_new[7:0]   = in_byte;
        2'd1:    length_new[15:8]  = in_byte;
        2'd2:    length_new[23:16] = in_byte;
        default: length_new[31:24] = in_byte;
      endcase
    end
  end

  // Negative, zero, or larger than the configured maximum.
  assign length_bad = length_new[31] || (length_new == 32'd0) ||
                      (length_new[30:FRAME_LEN_W] != '0) ||
                      (length_new[FRAME_LEN_W-1:0] > max_frame_len);

  assign payload_inc  = payload_count + FRAME_LEN_W'(1);
  assign payload_last = (payload_inc >= length_value[FRAME_LEN_W-1:0]);

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (header_done) begin
          phase_next = length_bad ? PH_HUNT : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_last) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = sync_hit ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  // Datapath and result.
  always_comb begin
    sync_window_next   = sync_window;
    header_count_next  = header_count;
    length_value_next  = length_value;
    payload_count_next = payload_count;
    result.valid       = 1'b0;
    result.data        = in_byte;
    result.last        = payload_last;
    result.length      = length_value[FRAME_LEN_W-1:0];
    unique case (phase)
      PH_HEADER: begin
        header_count_next = header_inc;
        length_value_next = length_new;
        if (header_done) begin
          header_count_next  = '0;
          payload_count_next = '0;
          if (length_bad) begin
            length_value_next = '0;
            sync_window_next  = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        result.valid = 1'b1;
        if (payload_last) begin
          sync_window_next   = '0;
          header_count_next  = '0;
          length_value_next  = '0;
          payload_count_next = '0;
        end else begin
          payload_count_next = payload_inc;
        end
      end
      default: begin
        if (sync_hit) begin
          sync_window_next   = '0;
          header_count_next  = HCW'(LEN_FIRST_BYTE);
          length_value_next  = '0;
          payload_count_next = '0;
        end else begin
          sync_window_next = window[23:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      sync_window   <= '0;
      header_count  <= '0;
      length_value  <= '0;
      payload_count <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      sync_window   <= sync_window_next;
      header_count  <= header_count_next;
      length_value  <= length_value_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

>>> hdl/sync_word_length_deframer.sv
// Top level of the sync word length deframer.
`timescale 1ns / 1ps

// The block takes a received byte stream, one byte per transfer, and hunts for
// the sync word AA BB CC DD with a sliding four-byte match. After a match it
// collects the rest of a HEADER_BYTES-long header, whose bytes four to seven
// hold a little-endian 32-bit payload length; the other header bytes are
// dropped. A length that is negative, zero or above max_frame_len drops the
// header and the hunt resumes. Otherwise the next length bytes come out one
// per transfer with tlast on the final one, and tdata also carries the frame
// length. Header and payload bytes never count toward a new sync word. Each
// input byte is handled in the cycle it is accepted, so one byte is taken
// every clock; the single output register is the only buffer, and input is
// taken whenever that register is empty or is being read in the same cycle.
// The maximum length register resets to 307200 and should be written only
// while no frame is in flight.
module sync_word_length_deframer #(
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: maximum accepted payload length in bytes.
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  // Input byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  // Payload byte stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [31:8] frame_length
  output logic        m_axis_tlast    // last_byte
);
  import swld_pkg::*;

  logic [FRAME_LEN_W-1:0] max_frame_len;
  logic                   in_fire;
  swld_result_t           result;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_data;
  logic                   out_last;
  logic [FRAME_LEN_W-1:0] out_length;

  // A new byte may enter whenever the output register will be free.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_frame_len <= cfg_wr_data;
    end
  end

  swld_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .in_byte       (s_axis_tdata),
    .max_frame_len (max_frame_len),
    .result        (result)
  );

  // Output register: loaded on every accepted byte, emptied when read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= result.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data   <= result.data;
      out_last   <= result.last;
      out_length <= result.length;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_length, out_data};
  assign m_axis_tlast  = out_last;

endmodule
